>>> src/csfc_pkg.sv
// Shared constants, types and the CRC-32C byte update for the trailer checker.
package csfc_pkg;

  localparam int unsigned TrailerBytes = 24;
  localparam int unsigned MagicEnd     = 8;
  localparam int unsigned SizeEnd      = 16;
  localparam int unsigned BodyEnd      = 20;
  localparam int unsigned CountMax     = 31;
  localparam int unsigned CntW         = 5;

  localparam int unsigned PaddrW = 4;
  localparam int unsigned PdataW = 64;

  localparam logic [PaddrW-1:0] RegMagicAddr = '0;

  localparam logic [31:0] CrcPoly = 32'h82F6_3B78;
  localparam logic [31:0] CrcInit = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    StatusOk     = 2'd0,
    StatusLength = 2'd1,
    StatusMagic  = 2'd2,
    StatusCrc    = 2'd3
  } status_e;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } tbyte_t;

  // Reflected CRC-32C update by one byte, one polynomial step per bit.
  function automatic logic [31:0] crc32c_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

>>> src/csfc_apb_regs.sv
// APB register file holding the expected magic word.
module csfc_apb_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [csfc_pkg::PaddrW-1:0]  paddr,
  input  logic [csfc_pkg::PdataW-1:0]  pwdata,
  output logic [csfc_pkg::PdataW-1:0]  prdata,
  output logic                         pready,
  output logic [63:0]                  magic_word_o
);

  logic [63:0] magic_q;
  logic        wr_magic;

  assign pready   = 1'b1;
  assign wr_magic = psel && penable && pwrite && (paddr == csfc_pkg::RegMagicAddr);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      magic_q <= '0;
    end else if (wr_magic) begin
      magic_q <= pwdata;
    end
  end

  assign prdata       = (paddr == csfc_pkg::RegMagicAddr) ? magic_q : '0;
  assign magic_word_o = magic_q;

endmodule

>>> src/csfc_input_stage.sv
// Input register for one trailer byte and its last mark.
module csfc_input_stage (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [7:0]       byte_value_i,
  input  logic             last_byte_i,
  output logic             item_vld_o,
  output csfc_pkg::tbyte_t item_o,
  input  logic             take_i
);

  logic             vld_q;
  csfc_pkg::tbyte_t item_q;
  logic             load;

  assign in_ready_o = !vld_q || take_i;
  assign load       = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (load) begin
      vld_q <= 1'b1;
    end else if (take_i) begin
      vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q.data <= byte_value_i;
      item_q.last <= last_byte_i;
    end
  end

  assign item_vld_o = vld_q;
  assign item_o     = item_q;

endmodule

>>> src/csfc_trailer_eval.sv
// Per-trailer state, byte-wide CRC and field capture, and the result register.
module csfc_trailer_eval (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [63:0]      magic_word_i,
  input  logic             item_vld_i,
  input  csfc_pkg::tbyte_t item_i,
  output logic             take_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [1:0]       footer_status_o,
  output logic [63:0]      pack_size_o,
  output logic [31:0]      pack_crc_o
);

  localparam int unsigned CntW = csfc_pkg::CntW;

  logic [CntW-1:0] cnt_q, cnt_d;
  logic [31:0]     crc_q, crc_d;
  logic            magic_q, magic_d;
  logic [63:0]     size_q, size_d;
  logic [31:0]     body_q, body_d;
  logic [31:0]     self_q, self_d;

  csfc_pkg::status_e status;

  logic        out_vld_q;
  logic [1:0]  status_q;
  logic [63:0] psize_q;
  logic [31:0] pcrc_q;
  logic        emit;

  // A byte without the last mark produces no result, so it never waits.
  assign take_o = item_vld_i && (!item_i.last || !out_vld_q || out_ready_i);
  assign emit   = take_o && item_i.last;

  always_comb begin
    logic [CntW-1:0] p;
    p       = cnt_q;
    magic_d = magic_q;
    crc_d   = crc_q;
    size_d  = size_q;
    body_d  = body_q;
    self_d  = self_q;

    if (p < CntW'(csfc_pkg::MagicEnd)) begin
      if (magic_word_i[{p[2:0], 3'b000} +: 8] != item_i.data) begin
        magic_d = 1'b0;
      end
    end
    if (p < CntW'(csfc_pkg::BodyEnd)) begin
      crc_d = csfc_pkg::crc32c_byte(crc_q, item_i.data);
    end
    if (p >= CntW'(csfc_pkg::MagicEnd) && p < CntW'(csfc_pkg::SizeEnd)) begin
      size_d[{p[2:0], 3'b000} +: 8] = item_i.data;
    end else if (p >= CntW'(csfc_pkg::SizeEnd) && p < CntW'(csfc_pkg::BodyEnd)) begin
      body_d[{p[1:0], 3'b000} +: 8] = item_i.data;
    end else if (p >= CntW'(csfc_pkg::BodyEnd) && p < CntW'(csfc_pkg::TrailerBytes)) begin
      self_d[{p[1:0], 3'b000} +: 8] = item_i.data;
    end

    cnt_d = (p != CntW'(csfc_pkg::CountMax)) ? p + CntW'(1) : p;

    if (cnt_d != CntW'(csfc_pkg::TrailerBytes)) begin
      status = csfc_pkg::StatusLength;
    end else if (!magic_d) begin
      status = csfc_pkg::StatusMagic;
    end else if ((crc_d ^ csfc_pkg::CrcInit) != self_d) begin
      status = csfc_pkg::StatusCrc;
    end else begin
      status = csfc_pkg::StatusOk;
    end
  end

  // The marked last byte closes the candidate and returns the state to reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      crc_q   <= csfc_pkg::CrcInit;
      magic_q <= 1'b1;
      size_q  <= '0;
      body_q  <= '0;
      self_q  <= '0;
    end else if (take_o) begin
      if (item_i.last) begin
        cnt_q   <= '0;
        crc_q   <= csfc_pkg::CrcInit;
        magic_q <= 1'b1;
        size_q  <= '0;
        body_q  <= '0;
        self_q  <= '0;
      end else begin
        cnt_q   <= cnt_d;
        crc_q   <= crc_d;
        magic_q <= magic_d;
        size_q  <= size_d;
        body_q  <= body_d;
        self_q  <= self_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (emit) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      status_q <= status;
      psize_q  <= (status == csfc_pkg::StatusOk) ? size_d : '0;
      pcrc_q   <= (status == csfc_pkg::StatusOk) ? body_d : '0;
    end
  end

  assign out_valid_o     = out_vld_q;
  assign footer_status_o = status_q;
  assign pack_size_o     = psize_q;
  assign pack_crc_o      = pcrc_q;

endmodule

>>> src/crc_sealed_footer_checker.sv
// Top level of the CRC-32C sealed trailer checker.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+----------------------------------
//   in      | input     | in_valid_i / in_ready_o | byte_value_i, last_byte_i
//   out     | output    | out_valid_o / out_ready_i | footer_status_o, pack_size_o,
//           |           |                        | pack_crc_o
//   apb     | input     | psel, penable, pwrite  | paddr, pwdata, prdata, pready
//
// One byte transfer is taken per cycle while no last byte waits. A byte passes through the input register and
// the combinational CRC and capture logic; a last byte loads the result register when it
// leaves the input register, and its result is then offered on out_valid_o.
// Reset is asynchronous, active low, and clears the magic word and the trailer state.
// Only a last byte waits on a full result register; other bytes keep flowing.
module crc_sealed_footer_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [7:0]                   byte_value_i,
  input  logic                         last_byte_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [1:0]                   footer_status_o,
  output logic [63:0]                  pack_size_o,
  output logic [31:0]                  pack_crc_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [csfc_pkg::PaddrW-1:0]  paddr,
  input  logic [csfc_pkg::PdataW-1:0]  pwdata,
  output logic [csfc_pkg::PdataW-1:0]  prdata,
  output logic                         pready
);

  logic [63:0]      magic_word;
  logic             item_vld;
  csfc_pkg::tbyte_t item;
  logic             take;

  csfc_apb_regs u_regs (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .magic_word_o (magic_word)
  );

  csfc_input_stage u_in (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .byte_value_i (byte_value_i),
    .last_byte_i  (last_byte_i),
    .item_vld_o   (item_vld),
    .item_o       (item),
    .take_i       (take)
  );

  csfc_trailer_eval u_eval (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .magic_word_i    (magic_word),
    .item_vld_i      (item_vld),
    .item_i          (item),
    .take_o          (take),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .footer_status_o (footer_status_o),
    .pack_size_o     (pack_size_o),
    .pack_crc_o      (pack_crc_o)
  );

endmodule

>>> tb/crc_sealed_footer_checker_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for the CRC-32C sealed trailer checker.
module crc_sealed_footer_checker_test;

  localparam logic [31:0] Castagnoli = 32'h82F6_3B78;
  localparam int unsigned MagicBytes = 8;
  localparam int unsigned SizeStop = 16;
  localparam int unsigned CrcStop = 20;
  localparam int unsigned FooterLen = 24;
  localparam int unsigned CountSat = 31;
  localparam int unsigned DrainCycles = 4;
  localparam int unsigned StuckLimit = 2000;
  localparam int unsigned PhaseBytes = 225;

  typedef struct packed {
    csfc_pkg::status_e status;
    logic [63:0]       size;
    logic [31:0]       body_crc;
  } footer_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [7:0] byte_value_i = 8'd0;
  logic last_byte_i = 1'b0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [1:0] footer_status_o;
  logic [63:0] pack_size_o;
  logic [31:0] pack_crc_o;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [csfc_pkg::PaddrW-1:0] paddr = '0;
  logic [csfc_pkg::PdataW-1:0] pwdata = '0;
  logic [csfc_pkg::PdataW-1:0] prdata;
  logic pready;

  // Trailer tracker: a copy of the checker state, advanced on every accepted byte.
  logic [63:0] magic_cfg = '0;
  logic [4:0] trk_count;
  logic [31:0] trk_crc;
  logic trk_magic_ok;
  logic [63:0] trk_size;
  logic [31:0] trk_body;
  logic [31:0] trk_self;

  footer_t expected_footers[$];
  footer_t oldest_footer;
  logic [7:0] cand_bytes[$];
  logic cand_last[$];

  bit tx_steady = 1'b0;
  bit rx_steady = 1'b0;
  int unsigned rx_stall_len = 0;
  int unsigned rx_hold;
  int unsigned rx_wait;
  int unsigned stuck_cycles = 0;
  int unsigned fail_count = 0;
  int unsigned bytes_sent = 0;
  int unsigned magic_writes = 0;
  int unsigned footers_checked = 0;
  int unsigned status_seen[4] = '{0, 0, 0, 0};

  crc_sealed_footer_checker uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .byte_value_i   (byte_value_i),
    .last_byte_i    (last_byte_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .footer_status_o(footer_status_o),
    .pack_size_o    (pack_size_o),
    .pack_crc_o     (pack_crc_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Bit-serial reflected CRC-32C: each data bit enters the feedback term in turn.
  function automatic logic [31:0] crc32c_update(input logic [31:0] crc, input logic [7:0] data);
    logic [31:0] r;
    r = crc;
    for (int i = 0; i < 8; i++) begin
      r = (r >> 1) ^ (Castagnoli & {32{r[0] ^ data[i]}});
    end
    return r;
  endfunction

  task automatic clear_tracker();
    trk_count = '0;
    trk_crc = 32'hFFFF_FFFF;
    trk_magic_ok = 1'b1;
    trk_size = '0;
    trk_body = '0;
    trk_self = '0;
  endtask

  task automatic fold_trailer_byte(input logic [7:0] b, input logic l);
    int unsigned p;
    footer_t f;
    p = 32'(trk_count);
    if (p < MagicBytes && magic_cfg[8*p +: 8] != b) begin
      trk_magic_ok = 1'b0;
    end
    if (p < CrcStop) begin
      trk_crc = crc32c_update(trk_crc, b);
    end
    if (p >= MagicBytes && p < SizeStop) begin
      trk_size[8*(p-MagicBytes) +: 8] = b;
    end else if (p >= SizeStop && p < CrcStop) begin
      trk_body[8*(p-SizeStop) +: 8] = b;
    end else if (p >= CrcStop && p < FooterLen) begin
      trk_self[8*(p-CrcStop) +: 8] = b;
    end
    if (trk_count < CountSat) begin
      trk_count = trk_count + 5'd1;
    end
    if (l) begin
      if (trk_count != FooterLen) begin
        f.status = csfc_pkg::StatusLength;
      end else if (!trk_magic_ok) begin
        f.status = csfc_pkg::StatusMagic;
      end else if (~trk_crc != trk_self) begin
        f.status = csfc_pkg::StatusCrc;
      end else begin
        f.status = csfc_pkg::StatusOk;
      end
      f.size = (f.status == csfc_pkg::StatusOk) ? trk_size : '0;
      f.body_crc = (f.status == csfc_pkg::StatusOk) ? trk_body : '0;
      expected_footers.push_back(f);
      clear_tracker();
    end
  endtask

  task automatic send_byte(input logic [7:0] b, input logic l);
    int unsigned gap;
    gap = tx_steady ? 0 : $urandom_range(0, 5);
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    byte_value_i = b;
    last_byte_i = l;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    fold_trailer_byte(b, l);
    bytes_sent++;
  endtask

  task automatic send_candidate();
    for (int i = 0; i < cand_bytes.size(); i++) begin
      send_byte(cand_bytes[i], cand_last[i]);
    end
    cand_bytes.delete();
    cand_last.delete();
  endtask

  task automatic add_byte(input logic [7:0] b, input logic l);
    cand_bytes.push_back(b);
    cand_last.push_back(l);
  endtask

  // A well-formed trailer under the current magic, with the self CRC sealed over bytes 0-19.
  task automatic build_trailer(input logic [63:0] size, input logic [31:0] body);
    logic [159:0] head;
    logic [31:0] seal;
    head = {body, size, magic_cfg};
    seal = 32'hFFFF_FFFF;
    cand_bytes.delete();
    cand_last.delete();
    for (int i = 0; i < CrcStop; i++) begin
      seal = crc32c_update(seal, head[8*i +: 8]);
      add_byte(head[8*i +: 8], 1'b0);
    end
    seal = ~seal;
    for (int i = 0; i < 4; i++) begin
      add_byte(seal[8*i +: 8], 1'b0);
    end
  endtask

  task automatic end_candidate();
    cand_last[cand_last.size()-1] = 1'b1;
  endtask

  task automatic wait_for_footers();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (expected_footers.size() != 0) @(posedge clk_i);
  endtask

  task automatic check_magic_readback();
    @(negedge clk_i);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = csfc_pkg::RegMagicAddr;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== magic_cfg) begin
      $display("%0t: magic readback expected %h actual %h", $time, magic_cfg, prdata);
      fail_count++;
    end
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
  endtask

  // The magic is only changed once the checker has gone quiet.
  task automatic program_magic(input logic [63:0] value);
    wait_for_footers();
    repeat (DrainCycles) @(posedge clk_i);
    @(negedge clk_i);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = csfc_pkg::RegMagicAddr;
    pwdata = value;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    magic_cfg = value;
    magic_writes++;
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    check_magic_readback();
  endtask

  task automatic test_reset_magic();
    check_magic_readback();
    build_trailer('0, '0);
    end_candidate();
    send_candidate();
  endtask

  task automatic test_field_extremes();
    program_magic('1);
    build_trailer('1, '1);
    end_candidate();
    send_candidate();
  endtask

  task automatic test_wrong_length();
    add_byte(8'hFF, 1'b1);
    send_candidate();
    // 56 bytes would wrap a 5-bit count back to 24 if it did not saturate.
    build_trailer({$urandom, $urandom}, $urandom);
    repeat (32) add_byte(8'($urandom_range(0, 255)), 1'b0);
    end_candidate();
    send_candidate();
  endtask

  task automatic test_mismatches();
    build_trailer({$urandom, $urandom}, $urandom);
    cand_bytes[MagicBytes-1] = cand_bytes[MagicBytes-1] ^ 8'h80;
    end_candidate();
    send_candidate();
    build_trailer({$urandom, $urandom}, $urandom);
    cand_bytes[FooterLen-1] = cand_bytes[FooterLen-1] ^ 8'h01;
    end_candidate();
    send_candidate();
  endtask

  // Hold the result side off long enough that a second last byte has to wait.
  task automatic test_backpressure();
    wait_for_footers();
    tx_steady = 1'b1;
    rx_stall_len = 80;
    repeat (4) begin
      build_trailer({$urandom, $urandom}, $urandom);
      end_candidate();
      send_candidate();
    end
    wait_for_footers();
    tx_steady = 1'b0;
  endtask

  task automatic send_random_candidate();
    int unsigned kind;
    int unsigned n;
    int unsigned k;
    kind = $urandom_range(0, 99);
    tx_steady = ($urandom_range(0, 4) == 0);
    rx_steady = ($urandom_range(0, 4) == 0);
    build_trailer({$urandom, $urandom}, $urandom);
    if (kind < 55) begin
      // well-formed trailer
    end else if (kind < 65) begin
      k = $urandom_range(0, MagicBytes - 1);
      cand_bytes[k] = cand_bytes[k] ^ (8'd1 << $urandom_range(0, 7));
    end else if (kind < 75) begin
      k = $urandom_range(MagicBytes, FooterLen - 1);
      cand_bytes[k] = cand_bytes[k] ^ (8'd1 << $urandom_range(0, 7));
    end else if (kind < 83) begin
      n = $urandom_range(1, FooterLen - 1);
      while (cand_bytes.size() > n) begin
        void'(cand_bytes.pop_back());
        void'(cand_last.pop_back());
      end
    end else if (kind < 90) begin
      n = (kind < 88) ? $urandom_range(1, 8) : $urandom_range(9, 32);
      repeat (n) add_byte(8'($urandom_range(0, 255)), 1'b0);
    end else begin
      // Noise: random bytes with last marks anywhere.
      cand_bytes.delete();
      cand_last.delete();
      n = $urandom_range(1, 32);
      repeat (n) add_byte(8'($urandom_range(0, 255)), $urandom_range(0, 5) == 0);
    end
    end_candidate();
    send_candidate();
    if ($urandom_range(0, 29) == 0) begin
      wait_for_footers();
    end
  endtask

  task automatic test_random_trailers();
    int unsigned phase_start;
    logic [63:0] value;
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: value = '0;
        1: value = '1;
        default: value = {$urandom, $urandom};
      endcase
      program_magic(value);
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < PhaseBytes) begin
        send_random_candidate();
      end
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  initial begin
    clear_tracker();
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    test_reset_magic();
    test_field_extremes();
    test_wrong_length();
    test_mismatches();
    test_backpressure();
    test_random_trailers();
    wait_for_footers();
    repeat (DrainCycles) @(posedge clk_i);
    $display("Sent %0d trailer bytes under %0d magic settings; checked %0d footers.",
             bytes_sent, magic_writes + 1, footers_checked);
    $display("Footer status mix: %0d valid, %0d length, %0d magic, %0d CRC.",
             status_seen[csfc_pkg::StatusOk], status_seen[csfc_pkg::StatusLength],
             status_seen[csfc_pkg::StatusMagic], status_seen[csfc_pkg::StatusCrc]);
    if (fail_count == 0 && expected_footers.size() == 0) begin
      $display("[crc_sealed_footer_checker] OK");
    end else begin
      $display("[crc_sealed_footer_checker] ERROR");
    end
    $finish;
  end

  // Result side: a random hold-off before each footer, or one long stall on request.
  initial begin
    wait (rst_ni === 1'b1);
    @(negedge clk_i);
    forever begin
      if (rx_stall_len != 0) begin
        out_ready_i = 1'b0;
        for (rx_hold = 0; rx_hold < rx_stall_len; rx_hold++) @(negedge clk_i);
        rx_stall_len = 0;
      end else begin
        rx_wait = rx_steady ? 0 : $urandom_range(0, 5);
        if (rx_wait != 0) begin
          out_ready_i = 1'b0;
          repeat (rx_wait) @(negedge clk_i);
        end
        out_ready_i = 1'b1;
        do @(posedge clk_i); while (!out_valid_o && rx_stall_len == 0);
        @(negedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_footers.size() == 0) begin
        $display("%0t: unexpected footer, status %0d size %h crc %h", $time,
                 footer_status_o, pack_size_o, pack_crc_o);
        fail_count++;
      end else begin
        oldest_footer = expected_footers.pop_front();
        footers_checked++;
        status_seen[oldest_footer.status]++;
        if (footer_status_o !== oldest_footer.status) begin
          $display("%0t: footer_status expected %0d actual %0d", $time,
                   oldest_footer.status, footer_status_o);
          fail_count++;
        end
        if (pack_size_o !== oldest_footer.size) begin
          $display("%0t: pack_size expected %h actual %h", $time,
                   oldest_footer.size, pack_size_o);
          fail_count++;
        end
        if (pack_crc_o !== oldest_footer.body_crc) begin
          $display("%0t: pack_crc expected %h actual %h", $time,
                   oldest_footer.body_crc, pack_crc_o);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: too long without any transfer on either channel means the run is stuck.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
    end
    if (stuck_cycles >= StuckLimit) begin
      $display("%0t: no transfer for %0d cycles, %0d footers outstanding", $time,
               stuck_cycles, expected_footers.size());
      $display("[crc_sealed_footer_checker] ERROR");
      $finish;
    end
  end

endmodule
